// ----- sv/rdr_pkg.sv -----
// rdr_pkg: shared types and constants for the radial deadzone rescaler
`timescale 1ns / 1ps
package rdr_pkg;

    // full-scale output and register reset
    localparam logic [14:0] FULL_SCALE   = 15'd32767;
    localparam logic [14:0] RADIUS_RESET = 15'd7849;
    localparam logic [29:0] RADIUS_SQ_RESET = 30'(32'd7849 * 32'd7849);

    // square root steps (one root bit each) and quotient bits below saturation
    localparam int SQRT_STEPS = 32;
    localparam int QBITS      = 15;

    // register index decoded from the byte address
    localparam logic REG_RADIUS = 1'b0;

    // per-item side data carried alongside the root pipeline
    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic [16:0] ax;
        logic [16:0] ay;
        logic        dead;
    } t_side;

    // per-item side data carried alongside the divider pipeline
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic dead;
    } t_dside;

endpackage

// ----- sv/radial_deadzone_rescale_top.sv -----
// radial_deadzone_rescale_top: stick deadzone and rescale pipeline with APB register
`timescale 1ns / 1ps
//  channel | signals                                  | handshake
//  in      | i_stick_x, i_stick_y, i_pad_connected    | i_valid / o_stall
//  out     | o_out_x, o_out_y                         | o_valid / i_stall
//  cfg     | psel penable pwrite paddr pwdata prdata  | pready tied high
//
//  one item per clock unless stalled; stages: 2 front, 32 root, 3 multiply, 16 divide,
//  1 sign and output register. length is set by the bit-serial root and divider stages.
//  reset clears all valid bits and loads radius 7849; no clearing pass.
//  a held result stalls every stage together; nothing is dropped or repeated.
module radial_deadzone_rescale_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_stick_x,
    input  logic signed [15:0] i_stick_y,
    input  logic               i_pad_connected,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rdr_pkg::*;

    logic en;

    // configuration register and its square
    logic [14:0] r_radius;
    logic [29:0] r_rsq;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && (paddr[2] == REG_RADIUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_rsq    <= RADIUS_SQ_RESET;
        end else if (wr) begin
            r_radius <= pwdata[14:0];
            r_rsq    <= pwdata[14:0] * pwdata[14:0];
        end
    end

    assign prdata = (paddr[2] == REG_RADIUS) ? {17'd0, r_radius} : 32'd0;

    // global advance: stop only when a result is held
    logic r_out_valid;
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // front stage 1: magnitudes and squares
    logic        r_f1_vld;
    logic        r_f1_negx, r_f1_negy, r_f1_conn;
    logic [16:0] r_f1_ax, r_f1_ay;
    logic [31:0] r_f1_sqx, r_f1_sqy;
    logic [16:0] n_ax, n_ay;

    assign n_ax = i_stick_x[15] ? 17'(17'd0 - {1'b1, i_stick_x}) : {1'b0, i_stick_x};
    assign n_ay = i_stick_y[15] ? 17'(17'd0 - {1'b1, i_stick_y}) : {1'b0, i_stick_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (en) begin
            r_f1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_negx <= i_stick_x[15];
            r_f1_negy <= i_stick_y[15];
            r_f1_conn <= i_pad_connected;
            r_f1_ax   <= n_ax;
            r_f1_ay   <= n_ay;
            r_f1_sqx  <= 32'(n_ax) * 32'(n_ax);
            r_f1_sqy  <= 32'(n_ay) * 32'(n_ay);
        end
    end

    // front stage 2: squared length and dead decision
    logic        r_f2_vld;
    logic [31:0] r_f2_s;
    t_side       r_f2_side;
    logic [31:0] n_s;

    assign n_s = r_f1_sqx + r_f1_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_vld <= 1'b0;
        end else if (en) begin
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_s          <= n_s;
            r_f2_side.neg_x <= r_f1_negx;
            r_f2_side.neg_y <= r_f1_negy;
            r_f2_side.ax    <= r_f1_ax;
            r_f2_side.ay    <= r_f1_ay;
            r_f2_side.dead  <= !r_f1_conn || (n_s < {2'b00, r_rsq})
                               || (r_radius == FULL_SCALE) || (n_s == 32'd0);
        end
    end

    // square root of s << 32
    logic        sq_vld;
    logic [31:0] sq_root;
    t_side       sq_side;

    rdr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f2_vld),
        .i_rad   (r_f2_s),
        .i_side  (r_f2_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // multiply stage 1: live width and denominator
    logic        r_m1_vld;
    logic [31:0] r_m1_live;
    logic [46:0] r_m1_den;
    t_side       r_m1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (en) begin
            r_m1_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_live <= sq_root - {1'b0, r_radius, 16'd0};
            r_m1_den  <= sq_root * (FULL_SCALE - r_radius);
            r_m1_side <= sq_side;
        end
    end

    // multiply stage 2: axis times live
    logic        r_m2_vld;
    logic [48:0] r_m2_px, r_m2_py;
    logic [46:0] r_m2_den;
    t_dside      r_m2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (en) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_px         <= r_m1_side.ax * r_m1_live;
            r_m2_py         <= r_m1_side.ay * r_m1_live;
            r_m2_den        <= r_m1_den;
            r_m2_side.neg_x <= r_m1_side.neg_x;
            r_m2_side.neg_y <= r_m1_side.neg_y;
            r_m2_side.dead  <= r_m1_side.dead;
        end
    end

    // multiply stage 3: times full scale as shift and subtract
    logic        r_m3_vld;
    logic [63:0] r_m3_nx, r_m3_ny;
    logic [46:0] r_m3_den;
    t_dside      r_m3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else if (en) begin
            r_m3_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_nx   <= {r_m2_px, 15'd0} - 64'(r_m2_px);
            r_m3_ny   <= {r_m2_py, 15'd0} - 64'(r_m2_py);
            r_m3_den  <= r_m2_den;
            r_m3_side <= r_m2_side;
        end
    end

    // divide
    logic        dv_vld;
    logic [14:0] dv_qx, dv_qy;
    t_dside      dv_side;

    rdr_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m3_vld),
        .i_num_x (r_m3_nx),
        .i_num_y (r_m3_ny),
        .i_den   (r_m3_den),
        .i_side  (r_m3_side),
        .o_valid (dv_vld),
        .o_q_x   (dv_qx),
        .o_q_y   (dv_qy),
        .o_side  (dv_side)
    );

    // output register: dead zeroing and sign
    logic [15:0] r_out_x, r_out_y;
    logic [15:0] mx, my;

    assign mx = dv_side.dead ? 16'd0 : {1'b0, dv_qx};
    assign my = dv_side.dead ? 16'd0 : {1'b0, dv_qy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x <= dv_side.neg_x ? 16'(16'd0 - mx) : mx;
            r_out_y <= dv_side.neg_y ? 16'(16'd0 - my) : my;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;

    // checks
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_x != 16'sh8000))
        else $error("out_x beyond full scale");
    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_y != 16'sh8000))
        else $error("out_y beyond full scale");
    a_stall_held: assert property (@(posedge i_clk)
        o_stall |-> o_valid)
        else $error("pipeline frozen without a held result");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// ----- sv/rdr_isqrt.sv -----
// rdr_isqrt: pipelined integer square root of rad << 32, one root bit per stage
`timescale 1ns / 1ps
module rdr_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [31:0]         i_rad,
    input  rdr_pkg::t_side      i_side,
    output logic                o_valid,
    output logic [31:0]         o_root,
    output rdr_pkg::t_side      o_side
);
    import rdr_pkg::*;

    logic [33:0] r_rem  [SQRT_STEPS];
    logic [31:0] r_root [SQRT_STEPS];
    logic [31:0] r_rad  [SQRT_STEPS];
    t_side       r_side [SQRT_STEPS];
    logic        r_vld  [SQRT_STEPS];

    genvar g;
    generate
        for (g = 0; g < SQRT_STEPS; g++) begin : g_step
            logic [33:0] rem_in;
            logic [31:0] root_in;
            logic [31:0] rad_in;
            t_side       side_in;
            logic        vld_in;
            logic [35:0] rem_sh;
            logic [35:0] trial;
            logic [33:0] n_rem;
            logic [31:0] n_root;

            // stage source: block input or previous stage
            if (g == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = i_rad;
                assign side_in = i_side;
                assign vld_in  = i_valid;
            end else begin : g_next
                assign rem_in  = r_rem[g-1];
                assign root_in = r_root[g-1];
                assign rad_in  = r_rad[g-1];
                assign side_in = r_side[g-1];
                assign vld_in  = r_vld[g-1];
            end

            // one restoring root digit: bring down two bits, try (root<<2)|1
            always_comb begin
                rem_sh = {rem_in, rad_in[31:30]};
                trial  = {2'b00, root_in, 2'b01};
                if (rem_sh >= trial) begin
                    n_rem  = 34'(rem_sh - trial);
                    n_root = {root_in[30:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[33:0];
                    n_root = {root_in[30:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g]  <= n_rem;
                    r_root[g] <= n_root;
                    r_rad[g]  <= {rad_in[29:0], 2'b00};
                    r_side[g] <= side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_root  = r_root[SQRT_STEPS-1];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule

// ----- sv/rdr_divider.sv -----
// rdr_divider: two-lane pipelined restoring divider with saturation at full scale
`timescale 1ns / 1ps
module rdr_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [63:0]         i_num_x,
    input  logic [63:0]         i_num_y,
    input  logic [46:0]         i_den,
    input  rdr_pkg::t_dside     i_side,
    output logic                o_valid,
    output logic [14:0]         o_q_x,
    output logic [14:0]         o_q_y,
    output rdr_pkg::t_dside     o_side
);
    import rdr_pkg::*;

    localparam int NST = QBITS + 1;

    logic [61:0] r_rem_x [NST];
    logic [61:0] r_rem_y [NST];
    logic [14:0] r_q_x   [NST];
    logic [14:0] r_q_y   [NST];
    logic        r_sat_x [NST];
    logic        r_sat_y [NST];
    logic [46:0] r_den   [NST];
    t_dside      r_side  [NST];
    logic        r_vld   [NST];

    genvar g;
    generate
        for (g = 0; g < NST; g++) begin : g_st
            logic [61:0] n_rem_x;
            logic [61:0] n_rem_y;
            logic [14:0] n_q_x;
            logic [14:0] n_q_y;
            logic        n_sat_x;
            logic        n_sat_y;
            logic [46:0] den_in;
            t_dside      side_in;
            logic        vld_in;

            if (g == 0) begin : g_sat
                logic [63:0] lim;
                // quotient reaches full scale + 1 when num >= den << 15
                assign lim     = {2'b00, i_den, 15'd0};
                assign n_sat_x = (i_num_x >= lim);
                assign n_sat_y = (i_num_y >= lim);
                assign n_rem_x = i_num_x[61:0];
                assign n_rem_y = i_num_y[61:0];
                assign n_q_x   = '0;
                assign n_q_y   = '0;
                assign den_in  = i_den;
                assign side_in = i_side;
                assign vld_in  = i_valid;
            end else begin : g_bit
                localparam int K = QBITS - g;
                logic [61:0] dsh;
                // one quotient bit per lane against den << K
                assign dsh     = 62'(r_den[g-1]) << K;
                assign n_sat_x = r_sat_x[g-1];
                assign n_sat_y = r_sat_y[g-1];
                assign den_in  = r_den[g-1];
                assign side_in = r_side[g-1];
                assign vld_in  = r_vld[g-1];
                always_comb begin
                    n_rem_x = r_rem_x[g-1];
                    n_q_x   = r_q_x[g-1];
                    if (r_rem_x[g-1] >= dsh) begin
                        n_rem_x  = r_rem_x[g-1] - dsh;
                        n_q_x[K] = 1'b1;
                    end
                    n_rem_y = r_rem_y[g-1];
                    n_q_y   = r_q_y[g-1];
                    if (r_rem_y[g-1] >= dsh) begin
                        n_rem_y  = r_rem_y[g-1] - dsh;
                        n_q_y[K] = 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem_x[g] <= n_rem_x;
                    r_rem_y[g] <= n_rem_y;
                    r_q_x[g]   <= n_q_x;
                    r_q_y[g]   <= n_q_y;
                    r_sat_x[g] <= n_sat_x;
                    r_sat_y[g] <= n_sat_y;
                    r_den[g]   <= den_in;
                    r_side[g]  <= side_in;
                end
            end
        end
    endgenerate

    // saturated lanes give full scale
    assign o_valid = r_vld[NST-1];
    assign o_q_x   = r_sat_x[NST-1] ? FULL_SCALE : r_q_x[NST-1];
    assign o_q_y   = r_sat_y[NST-1] ? FULL_SCALE : r_q_y[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for the radial deadzone rescaler
`timescale 1ns / 1ps
module testbench;
    import rdr_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_stick_x;
    logic signed [15:0] i_stick_y;
    logic               i_pad_connected;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               conn;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_stick_out;

    localparam int LATENCY   = 54;
    localparam int WD_LIMIT  = 2000;
    localparam int HOLD_LEN  = 300;

    t_sample    pending_samples[$];
    t_stick_out expected_sticks[$];
    logic [14:0] radius;
    int          n_errors;
    int          n_sent;
    int          n_checked;
    int          idle_cycles;
    bit          quiet_mode;
    bit          hold_req;
    int          in_gap;
    int          out_gap;
    int          hold_left;

    radial_deadzone_rescale_top u_dut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // integer square root of a 64-bit value
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // scale one axis by full scale * live/(m*span), saturate, restore sign
    function automatic logic signed [15:0] scale_axis(input logic signed [15:0] a,
                                                      input logic [63:0] m,
                                                      input logic [63:0] live,
                                                      input logic [63:0] span);
        logic [63:0]  mag;
        logic [127:0] q;
        logic [63:0]  den;
        mag = (a < 0) ? 64'(-32'(a)) : 64'(a);
        den = m * span;
        if (den == 0) return 16'sd0;
        q = (128'(mag) * 128'(live) * 128'd32767) / 128'(den);
        if (q > 128'd32767) q = 128'd32767;
        return (a < 0) ? -16'(q) : 16'(q);
    endfunction

    // expected deadzone-rescaled stick for one sample
    function automatic t_stick_out deadzone_rescale(input t_sample s, input logic [14:0] r);
        t_stick_out  res;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] sq;
        logic [63:0] m;
        ax = (s.x < 0) ? 64'(-32'(s.x)) : 64'(s.x);
        ay = (s.y < 0) ? 64'(-32'(s.y)) : 64'(s.y);
        sq = ax * ax + ay * ay;
        res = '0;
        if (!s.conn || sq < 64'(r) * 64'(r) || r >= FULL_SCALE) return res;
        m = int_sqrt(sq << 32);
        res.x = scale_axis(s.x, m, m - (64'(r) << 16), 64'(FULL_SCALE) - 64'(r));
        res.y = scale_axis(s.y, m, m - (64'(r) << 16), 64'(FULL_SCALE) - 64'(r));
        return res;
    endfunction

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 600)) - 16'sd300;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic c);
        t_sample s;
        s.x = x;
        s.y = y;
        s.conn = c;
        pending_samples.push_back(s);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("mismatch on %s at item %0d: got %0d expected %0d", what, n_checked, got,
                 want);
    endtask

    task automatic write_radius(input logic [14:0] r);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {REG_RADIUS, 2'b00};
        pwdata  <= 32'(r);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== 32'(r)) report_mismatch("radius readback", int'(prdata), int'(r));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        radius = r;
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || expected_sticks.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    // driver: offers the head of the queue, with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                n_sent++;
                void'(pending_samples.pop_front());
            end
            if (!i_valid || !o_stall) begin
                if (in_gap == 0 && !quiet_mode && $urandom_range(0, 9) == 0)
                    in_gap = $urandom_range(1, 4);
                if (in_gap > 0) begin
                    in_gap--;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    i_valid         <= 1'b1;
                    i_stick_x       <= pending_samples[0].x;
                    i_stick_y       <= pending_samples[0].y;
                    i_pad_connected <= pending_samples[0].conn;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: random bursts plus one long hold
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) hold_left = HOLD_LEN;
        if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_req = 1'b0;
            i_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            i_stall <= 1'b1;
        end else begin
            if (!quiet_mode && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 4);
            i_stall <= 1'b0;
        end
    end

    // monitor: predict at input acceptance, check at output acceptance
    always @(posedge i_clk) begin
        t_stick_out want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_sticks.push_back(deadzone_rescale(
                    t_sample'{i_stick_x, i_stick_y, i_pad_connected}, radius));
            end
            if (o_valid && !i_stall) begin
                if (expected_sticks.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    want = expected_sticks.pop_front();
                    if (o_out_x !== want.x) report_mismatch("out_x", o_out_x, want.x);
                    if (o_out_y !== want.y) report_mismatch("out_y", o_out_y, want.y);
                end
                n_checked++;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (idle_cycles >= WD_LIMIT && hold_left == 0) begin
            $display("radial_deadzone_rescale_top test failed");
            $finish;
        end
    end

    initial begin
        logic [14:0] radii[6];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_stick_x = '0;
        i_stick_y = '0;
        i_pad_connected = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        radius = RADIUS_RESET;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        quiet_mode = 1'b0;
        hold_req = 1'b0;
        in_gap = 0;
        out_gap = 0;
        hold_left = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, disconnect, dead region edge, saturation
        push_sample(16'sh7fff, 16'sh0000, 1'b1);
        push_sample(16'sh8000, 16'sh0000, 1'b1);
        push_sample(16'sh8000, 16'sh8000, 1'b1);
        push_sample(16'sh7fff, 16'sh7fff, 1'b1);
        push_sample(16'sh7fff, 16'sh8000, 1'b1);
        push_sample(16'sh7fff, 16'sh7fff, 1'b0);
        push_sample(16'sh0000, 16'sh0000, 1'b1);
        push_sample(16'sd7849, 16'sd0, 1'b1);
        push_sample(16'sd7848, 16'sd0, 1'b1);
        push_sample(16'sd0, -16'sd7849, 1'b1);
        push_sample(16'sd5550, 16'sd5550, 1'b1);
        push_sample(-16'sd20000, 16'sd12345, 1'b1);
        push_sample(16'shffff, 16'sh5555, 1'b1);
        push_sample(16'shaaaa, 16'sh0001, 1'b1);
        drain();

        // zero radius with zero vector, then top of range and smaller radii
        radii = '{15'd0, 15'd32766, 15'd32767, 15'd1, 15'd16000, 15'd7849};
        foreach (radii[k]) begin
            write_radius(radii[k]);
            push_sample(16'sd0, 16'sd0, 1'b1);
            push_sample(16'sh7fff, 16'sd0, 1'b1);
            push_sample(16'sh8000, 16'sh8000, 1'b1);
            push_sample(16'sd1, -16'sd1, 1'b1);
            if (k == 3) hold_req = 1'b1;
            for (int n = 0; n < 270; n++) begin
                push_sample(rand_axis(), rand_axis(), $urandom_range(0, 7) != 0);
                if (k == 5 && n == 150) quiet_mode = 1'b1;
            end
            drain();
        end

        $display("sent %0d and checked %0d items across %0d radius settings incl. 0, 32766, 32767",
                 n_sent, n_checked, 7);
        $display("directed extremes, disconnects, dead edge and a long receiver hold");
        if (n_errors == 0) begin
            $display("radial_deadzone_rescale_top test passed");
        end else begin
            $display("radial_deadzone_rescale_top test failed");
        end
        $finish;
    end

endmodule
